### rtl/quantile_buffer_collapse_macros.svh
// Assertion macros used by the quantile buffer collapse RTL.
`ifndef QUANTILE_BUFFER_COLLAPSE_MACROS_SVH
`define QUANTILE_BUFFER_COLLAPSE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QBC_ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("qbc assertion failed");

// Next-cycle implication, disabled during reset.
`define QBC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("qbc assertion failed");

`endif

### rtl/qbc_pkg.sv
// Package of types, codes and constants for the quantile buffer collapse block.
package qbc_pkg;

  localparam int NUM_BUFFERS_DEF = 8;
  localparam int BUFFER_SIZE_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W      = 3;
  localparam int IDX_W      = 3;
  localparam int POS_W      = 6;
  localparam int DATA_W     = 32;
  localparam int WEIGHT_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int NBUF_REG_W = 4;
  localparam int SIZE_REG_W = 7;
  localparam int PADDR_W    = 3;
  localparam int MCOUNT_W   = SIZE_REG_W + 1;
  localparam int ACC_W      = 24;

  localparam logic [NBUF_REG_W-1:0] NBUF_RESET = 4'd8;
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 7'd64;

  // Register select is address bit 2.
  localparam logic REG_BUFFERS_IN_USE = 1'b0;
  localparam logic REG_SIZE_IN_USE    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_WEIGHT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW    = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE       = 3'd0,
    CMD_READ        = 3'd1,
    CMD_SET_WEIGHT  = 3'd2,
    CMD_COLLAPSE    = 3'd3,
    CMD_READ_WEIGHT = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_WAIT,
    ST_W_CHECK,
    ST_PRIME_A,
    ST_PRIME_B,
    ST_MERGE,
    ST_MERGE_WAIT,
    ST_SEL_START,
    ST_SEL_LOAD,
    ST_SEL_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [NBUF_REG_W-1:0] num_buffers;
    logic [SIZE_REG_W-1:0] size;
  } cfg_t;

endpackage

### rtl/qbc_ram.sv
// Single-port synchronous RAM with registered read data.
module qbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/qbc_ctrl.sv
// Command sequencer with weight table, merge walk and quantile selection.
`include "quantile_buffer_collapse_macros.svh"

module qbc_ctrl #(
  parameter int NUM_BUFFERS = qbc_pkg::NUM_BUFFERS_DEF,
  parameter int BUFFER_SIZE = qbc_pkg::BUFFER_SIZE_DEF,
  parameter int VALUE_WIDTH = qbc_pkg::VALUE_WIDTH_DEF,
  localparam int AW = $clog2(NUM_BUFFERS * BUFFER_SIZE),
  localparam int MW = $clog2(2 * BUFFER_SIZE)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  qbc_pkg::cfg_t                   cfg,
  input  logic                            start,
  input  logic [qbc_pkg::CMD_W-1:0]       command,
  input  logic [qbc_pkg::IDX_W-1:0]       buffer_index,
  input  logic [qbc_pkg::IDX_W-1:0]       second_index,
  input  logic [qbc_pkg::POS_W-1:0]       position,
  input  logic [qbc_pkg::DATA_W-1:0]      value,
  input  logic [qbc_pkg::WEIGHT_W-1:0]    weight,
  output logic                            busy,
  output logic                            done,
  output logic [qbc_pkg::STATUS_W-1:0]    status,
  output logic [qbc_pkg::DATA_W-1:0]      read_value,
  output logic [qbc_pkg::WEIGHT_W-1:0]    read_weight,
  output logic                            elem_we,
  output logic [AW-1:0]                   elem_addr,
  output logic [VALUE_WIDTH-1:0]          elem_wdata,
  input  logic [VALUE_WIDTH-1:0]          elem_rdata,
  output logic                            scr_we,
  output logic [MW-1:0]                   scr_addr,
  output logic [VALUE_WIDTH:0]            scr_wdata,
  input  logic [VALUE_WIDTH:0]            scr_rdata
);

  localparam int NIW = $clog2(NUM_BUFFERS);
  localparam int KW  = qbc_pkg::SIZE_REG_W;
  localparam int CW  = qbc_pkg::MCOUNT_W;
  localparam int WW  = qbc_pkg::WEIGHT_W;

  qbc_pkg::state_t state, state_next;

  logic [qbc_pkg::CMD_W-1:0]  cmd;
  logic [qbc_pkg::IDX_W-1:0]  bi, si, widx;
  logic [qbc_pkg::POS_W-1:0]  pos;
  logic [qbc_pkg::DATA_W-1:0] val;
  logic [WW-1:0]              wt, w1, w2, total, wrd;
  logic [WW-1:0]              weights [NUM_BUFFERS];
  logic [qbc_pkg::ACC_W-1:0]  acc, thr;
  logic [KW-1:0]              ia, ib, jj, k;
  logic [CW-1:0]              n, m, k2;
  logic [VALUE_WIDTH-1:0]     head_a, head_b, sel_val;
  logic                       last_a, take_a;
  logic [qbc_pkg::NBUF_REG_W-1:0] nb;
  logic                       bad_bi, bad_si, bad_pos, sel_hit;
  logic [WW:0]                sum;
  logic [63:0]                rd_ext, val_ext;

  assign nb = (32'(cfg.num_buffers) > NUM_BUFFERS) ?
              qbc_pkg::NBUF_REG_W'(NUM_BUFFERS) : cfg.num_buffers;
  assign k  = (32'(cfg.size) > BUFFER_SIZE) ? KW'(BUFFER_SIZE) : cfg.size;
  assign k2 = CW'(k) + CW'(k);

  assign bad_bi  = {1'b0, bi} >= nb;
  assign bad_si  = {1'b0, si} >= nb;
  assign bad_pos = {1'b0, pos} >= k;

  assign widx = (state == qbc_pkg::ST_W_CHECK) ? si : bi;
  assign wrd  = weights[NIW'(32'(widx))];
  assign sum  = {1'b0, w1} + {1'b0, wrd};

  // Ties go to the first buffer.
  assign take_a = (ia < k) && ((ib >= k) || ($signed(head_a) <= $signed(head_b)));
  assign sel_hit = (jj < k) && (acc >= thr);

  assign rd_ext  = 64'(signed'(elem_rdata));
  assign val_ext = 64'(val);
  assign busy    = (state != qbc_pkg::ST_IDLE);

  function automatic logic [AW-1:0] eaddr(logic [qbc_pkg::IDX_W-1:0] b, logic [KW-1:0] o);
    eaddr = AW'(32'(b) * BUFFER_SIZE + 32'(o));
  endfunction

  always_comb begin
    state_next = state;
    elem_we    = 1'b0;
    elem_addr  = eaddr(bi, KW'(pos));
    elem_wdata = val_ext[VALUE_WIDTH-1:0];
    scr_we     = 1'b0;
    scr_addr   = MW'(32'(n));
    scr_wdata  = {take_a, (take_a ? head_a : head_b)};
    case (state)
      qbc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = qbc_pkg::ST_DECODE;
        end
      end
      qbc_pkg::ST_DECODE: begin
        state_next = qbc_pkg::ST_IDLE;
        case (cmd)
          qbc_pkg::CMD_WRITE: begin
            elem_we = !(bad_bi || bad_pos);
          end
          qbc_pkg::CMD_READ: begin
            if (!(bad_bi || bad_pos)) begin
              state_next = qbc_pkg::ST_RD_WAIT;
            end
          end
          qbc_pkg::CMD_COLLAPSE: begin
            if (!(bad_bi || bad_si || bi == si)) begin
              state_next = qbc_pkg::ST_W_CHECK;
            end
          end
          default: begin
            state_next = qbc_pkg::ST_IDLE;
          end
        endcase
      end
      qbc_pkg::ST_RD_WAIT: begin
        state_next = qbc_pkg::ST_IDLE;
      end
      qbc_pkg::ST_W_CHECK: begin
        elem_addr = eaddr(bi, '0);
        if (w1 == '0 || wrd == '0 || sum[WW]) begin
          state_next = qbc_pkg::ST_IDLE;
        end else if (k == '0) begin
          state_next = qbc_pkg::ST_FINISH;
        end else begin
          state_next = qbc_pkg::ST_PRIME_A;
        end
      end
      qbc_pkg::ST_PRIME_A: begin
        elem_addr  = eaddr(si, '0);
        state_next = qbc_pkg::ST_PRIME_B;
      end
      qbc_pkg::ST_PRIME_B: begin
        state_next = qbc_pkg::ST_MERGE;
      end
      qbc_pkg::ST_MERGE: begin
        scr_we = 1'b1;
        if (n + CW'(1) == k2) begin
          state_next = qbc_pkg::ST_SEL_START;
        end else if (take_a && (ia + KW'(1) < k)) begin
          elem_addr  = eaddr(bi, ia + KW'(1));
          state_next = qbc_pkg::ST_MERGE_WAIT;
        end else if (!take_a && (ib + KW'(1) < k)) begin
          elem_addr  = eaddr(si, ib + KW'(1));
          state_next = qbc_pkg::ST_MERGE_WAIT;
        end
      end
      qbc_pkg::ST_MERGE_WAIT: begin
        state_next = qbc_pkg::ST_MERGE;
      end
      qbc_pkg::ST_SEL_START: begin
        scr_addr   = '0;
        state_next = qbc_pkg::ST_SEL_LOAD;
      end
      qbc_pkg::ST_SEL_LOAD: begin
        state_next = qbc_pkg::ST_SEL_CMP;
      end
      qbc_pkg::ST_SEL_CMP: begin
        if (sel_hit) begin
          elem_we    = 1'b1;
          elem_addr  = eaddr(bi, jj);
          elem_wdata = sel_val;
        end else if (jj >= k || m + CW'(1) == k2) begin
          state_next = qbc_pkg::ST_FINISH;
        end else begin
          scr_addr   = MW'(32'(m + CW'(1)));
          state_next = qbc_pkg::ST_SEL_LOAD;
        end
      end
      qbc_pkg::ST_FINISH: begin
        state_next = qbc_pkg::ST_IDLE;
      end
      default: begin
        state_next = qbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qbc_pkg::ST_IDLE;
      done  <= 1'b0;
      for (int e = 0; e < NUM_BUFFERS; e++) begin
        weights[e] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        qbc_pkg::ST_IDLE: begin
          if (start) begin
            cmd <= command;
            bi  <= buffer_index;
            si  <= second_index;
            pos <= position;
            val <= value;
            wt  <= weight;
          end
        end
        qbc_pkg::ST_DECODE: begin
          read_value  <= '0;
          read_weight <= '0;
          status      <= qbc_pkg::STATUS_OK;
          case (cmd)
            qbc_pkg::CMD_WRITE: begin
              done <= 1'b1;
              if (bad_bi || bad_pos) begin
                status <= qbc_pkg::STATUS_RANGE;
              end
            end
            qbc_pkg::CMD_READ: begin
              if (bad_bi || bad_pos) begin
                done   <= 1'b1;
                status <= qbc_pkg::STATUS_RANGE;
              end
            end
            qbc_pkg::CMD_SET_WEIGHT: begin
              done <= 1'b1;
              if (bad_bi) begin
                status <= qbc_pkg::STATUS_RANGE;
              end else begin
                weights[NIW'(32'(bi))] <= wt;
              end
            end
            qbc_pkg::CMD_READ_WEIGHT: begin
              done <= 1'b1;
              if (bad_bi) begin
                status <= qbc_pkg::STATUS_RANGE;
              end else begin
                read_weight <= wrd;
              end
            end
            qbc_pkg::CMD_COLLAPSE: begin
              w1 <= wrd;
              if (bad_bi || bad_si || bi == si) begin
                done   <= 1'b1;
                status <= qbc_pkg::STATUS_RANGE;
              end
            end
            default: begin
              done   <= 1'b1;
              status <= qbc_pkg::STATUS_RANGE;
            end
          endcase
        end
        qbc_pkg::ST_RD_WAIT: begin
          done       <= 1'b1;
          read_value <= rd_ext[qbc_pkg::DATA_W-1:0];
        end
        qbc_pkg::ST_W_CHECK: begin
          w2    <= wrd;
          total <= sum[WW-1:0];
          thr   <= qbc_pkg::ACC_W'(sum[WW-1:1]);
          acc   <= '0;
          ia    <= '0;
          ib    <= '0;
          jj    <= '0;
          n     <= '0;
          m     <= '0;
          if (w1 == '0 || wrd == '0) begin
            done   <= 1'b1;
            status <= qbc_pkg::STATUS_ZERO_WEIGHT;
          end else if (sum[WW]) begin
            done   <= 1'b1;
            status <= qbc_pkg::STATUS_OVERFLOW;
          end
        end
        qbc_pkg::ST_PRIME_A: begin
          head_a <= elem_rdata;
        end
        qbc_pkg::ST_PRIME_B: begin
          head_b <= elem_rdata;
        end
        qbc_pkg::ST_MERGE: begin
          n      <= n + CW'(1);
          last_a <= take_a;
          if (take_a) begin
            ia <= ia + KW'(1);
          end else begin
            ib <= ib + KW'(1);
          end
        end
        qbc_pkg::ST_MERGE_WAIT: begin
          if (last_a) begin
            head_a <= elem_rdata;
          end else begin
            head_b <= elem_rdata;
          end
        end
        qbc_pkg::ST_SEL_LOAD: begin
          acc     <= acc + qbc_pkg::ACC_W'(scr_rdata[VALUE_WIDTH] ? w1 : w2);
          sel_val <= scr_rdata[VALUE_WIDTH-1:0];
        end
        qbc_pkg::ST_SEL_CMP: begin
          if (sel_hit) begin
            jj  <= jj + KW'(1);
            thr <= thr + qbc_pkg::ACC_W'(total);
          end else begin
            m <= m + CW'(1);
          end
        end
        qbc_pkg::ST_FINISH: begin
          done                   <= 1'b1;
          read_weight            <= total;
          weights[NIW'(32'(bi))] <= total;
          weights[NIW'(32'(si))] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  `QBC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `QBC_ASSERT_IMPLY(a_done_after_work, clk, rst, done, $past(state) != qbc_pkg::ST_IDLE)
  `QBC_ASSERT_IMPLY(a_merge_bound, clk, rst, state == qbc_pkg::ST_MERGE, n < k2)
  `QBC_ASSERT_IMPLY(a_select_bound, clk, rst, state == qbc_pkg::ST_SEL_CMP && elem_we, jj < k)

endmodule

### rtl/quantile_buffer_collapse.sv
// Top level: register port, command sequencer, element store and merge scratch.
// Write element, set weight and read weight finish straight from decode; read element waits
// on the registered store read, and a collapse runs a merge and a quantile pick that each
// walk the single-port element store and merge scratch.
// One item at a time: busy stays high until done; done is a one-cycle strobe.
// Reset clears the weights and sets buffers_in_use to 8 and size_in_use to 64, not the store.
module quantile_buffer_collapse #(
  parameter int NUM_BUFFERS = qbc_pkg::NUM_BUFFERS_DEF,
  parameter int BUFFER_SIZE = qbc_pkg::BUFFER_SIZE_DEF,
  parameter int VALUE_WIDTH = qbc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qbc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  input  logic [qbc_pkg::CMD_W-1:0]     command,
  input  logic [qbc_pkg::IDX_W-1:0]     buffer_index,
  input  logic [qbc_pkg::IDX_W-1:0]     second_index,
  input  logic [qbc_pkg::POS_W-1:0]     position,
  input  logic [qbc_pkg::DATA_W-1:0]    value,
  input  logic [qbc_pkg::WEIGHT_W-1:0]  weight,
  output logic                          busy,
  output logic                          done,
  output logic [qbc_pkg::STATUS_W-1:0]  status,
  output logic [qbc_pkg::DATA_W-1:0]    read_value,
  output logic [qbc_pkg::WEIGHT_W-1:0]  read_weight
);

  localparam int AW = $clog2(NUM_BUFFERS * BUFFER_SIZE);
  localparam int MW = $clog2(2 * BUFFER_SIZE);

  // Configuration registers. Address bit 2 selects the register; both are to be
  // written only while no item is in flight, which the block itself does not enforce.
  qbc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_buffers <= qbc_pkg::NBUF_RESET;
      cfg.size        <= qbc_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == qbc_pkg::REG_SIZE_IN_USE) begin
        cfg.size <= pwdata[qbc_pkg::SIZE_REG_W-1:0];
      end else begin
        cfg.num_buffers <= pwdata[qbc_pkg::NBUF_REG_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == qbc_pkg::REG_BUFFERS_IN_USE) ?
                  32'(cfg.num_buffers) : 32'(cfg.size);

  logic                   elem_we, scr_we;
  logic [AW-1:0]          elem_addr;
  logic [MW-1:0]          scr_addr;
  logic [VALUE_WIDTH-1:0] elem_wdata, elem_rdata;
  logic [VALUE_WIDTH:0]   scr_wdata, scr_rdata;

  // The sequencer decodes each item, keeps the weight table and runs the
  // two phases of a collapse: a merge walk that writes the merged sequence,
  // tagged with its source buffer, into the scratch, then a pick pass that
  // accumulates weights and writes each quantile back into the first buffer.
  qbc_ctrl #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .BUFFER_SIZE (BUFFER_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .command      (command),
    .buffer_index (buffer_index),
    .second_index (second_index),
    .position     (position),
    .value        (value),
    .weight       (weight),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .read_value   (read_value),
    .read_weight  (read_weight),
    .elem_we      (elem_we),
    .elem_addr    (elem_addr),
    .elem_wdata   (elem_wdata),
    .elem_rdata   (elem_rdata),
    .scr_we       (scr_we),
    .scr_addr     (scr_addr),
    .scr_wdata    (scr_wdata),
    .scr_rdata    (scr_rdata)
  );

  // Element store: every buffer laid end to end.
  qbc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (NUM_BUFFERS * BUFFER_SIZE)
  ) u_elem_store (
    .clk   (clk),
    .we    (elem_we),
    .addr  (elem_addr),
    .wdata (elem_wdata),
    .rdata (elem_rdata)
  );

  // Merge scratch: value plus a flag marking an element from the first buffer.
  qbc_ram #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (2 * BUFFER_SIZE)
  ) u_merge_scratch (
    .clk   (clk),
    .we    (scr_we),
    .addr  (scr_addr),
    .wdata (scr_wdata),
    .rdata (scr_rdata)
  );

endmodule
